[rtl/accel_tilt_pitch_angle_assert.svh]
// ----------------------------------------------------------------------------
// accel_tilt_pitch_angle assertion macros
// Shorthand for the clocked property checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_PITCH_ANGLE_ASSERT_SVH
`define ACCEL_TILT_PITCH_ANGLE_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define ATP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define ATP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define ATP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/atp_pkg.sv]
// ----------------------------------------------------------------------------
// atp_pkg
// Shared widths, constants and stage types for the tilt pitch pipeline.
// ----------------------------------------------------------------------------
package atp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    // input / output field widths
    localparam int IN_W    = 16;
    localparam int ANGLE_W = 15;
    localparam int RATE_W  = 16;

    // square root chain: 48-bit radicand, one result bit per cell
    localparam int HSQ_W      = 32;
    localparam int SQRT_STEPS = 24;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = ROOT_W + 2;

    // CORDIC datapath
    localparam int XY_W = 27;
    localparam int Z_W  = 24;

    localparam int PITCH_LIMIT = 11520;

    // rate = round(|gy| * 40 / 41) through a reciprocal multiply
    localparam int RATE_N_W    = 21;
    localparam int RATE_PROD_W = 42;
    localparam int RATE_SHIFT  = 26;
    localparam int RATE_RECIP  = 1636802;   // ceil(2^26 / 41)
    localparam int RATE_BIAS   = 20;

    typedef logic signed [Z_W-1:0] atan_t;

    // round(atan(2^-i) in degrees * 2^15)
    localparam atan_t ATAN_TABLE [ATAN_ENTRIES] = '{
        24'sd1474560, 24'sd870484, 24'sd459940, 24'sd233473,
        24'sd117189,  24'sd58652,  24'sd29333,  24'sd14667,
        24'sd7334,    24'sd3667,   24'sd1833,   24'sd917,
        24'sd458,     24'sd229,    24'sd115,    24'sd57,
        24'sd29,      24'sd14,     24'sd7,      24'sd4,
        24'sd2,       24'sd1,      24'sd0,      24'sd0
    };

    typedef struct packed {
        logic enable;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [RAD_W-1:0]       rad;
        logic [REM_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
        logic signed [IN_W-1:0] ay;
        logic                   zero_vec;
    } sqrt_stage_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero_vec;
    } cordic_stage_t;

endpackage

[rtl/atp_rate.sv]
// ----------------------------------------------------------------------------
// atp_rate
// Three-stage gyro scaling: round(gyro_y * 40 / 41) by reciprocal multiply.
// ----------------------------------------------------------------------------
module atp_rate import atp_pkg::*; (
    input  logic                     aclk,
    input  pipe_ctrl_t               ctrl,
    input  logic signed [IN_W-1:0]   gyro_y,
    output logic signed [RATE_W-1:0] rate
);

    logic signed [IN_W:0]     gy_ext;
    logic [IN_W:0]            mag;
    logic [RATE_N_W-1:0]      n_next, n_reg;
    logic                     neg_a_reg, neg_b_reg;
    logic [RATE_PROD_W-1:0]   prod_next, prod_reg;
    logic [RATE_W-1:0]        quot;
    logic signed [RATE_W-1:0] rate_next, rate_reg;

    always_comb begin
        gy_ext = {gyro_y[IN_W-1], gyro_y};
        mag    = gy_ext[IN_W] ? (IN_W+1)'(-gy_ext) : (IN_W+1)'(gy_ext);
        // |gy| * 40 + 20
        n_next = RATE_N_W'({mag, 5'b0} + {2'b0, mag, 3'b0} + (IN_W+6)'(RATE_BIAS));
    end

    assign prod_next = RATE_PROD_W'(n_reg) * RATE_PROD_W'(RATE_RECIP);

    always_comb begin
        quot      = prod_reg[RATE_SHIFT +: RATE_W];
        rate_next = neg_b_reg ? RATE_W'(0 - quot) : RATE_W'(quot);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.enable) begin
            n_reg     <= n_next;
            neg_a_reg <= gyro_y[IN_W-1];
            prod_reg  <= prod_next;
            neg_b_reg <= neg_a_reg;
            rate_reg  <= rate_next;
        end
    end

    assign rate = rate_reg;

endmodule

[rtl/atp_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// atp_sqrt_cell
// One restoring square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module atp_sqrt_cell import atp_pkg::*; (
    input  logic        aclk,
    input  pipe_ctrl_t  ctrl,
    input  sqrt_stage_t stage_in,
    output sqrt_stage_t stage_out
);

    logic [REM_W+1:0] rem_shift;
    logic [REM_W+1:0] trial;
    sqrt_stage_t      stage_next, stage_reg;

    always_comb begin
        rem_shift  = {stage_in.rem, stage_in.rad[RAD_W-1 -: 2]};
        trial      = {{(REM_W-ROOT_W){1'b0}}, stage_in.root, 2'b01};
        stage_next = stage_in;
        stage_next.rad = {stage_in.rad[RAD_W-3:0], 2'b00};
        if (rem_shift >= trial) begin
            stage_next.rem  = REM_W'(rem_shift - trial);
            stage_next.root = {stage_in.root[ROOT_W-2:0], 1'b1};
        end else begin
            stage_next.rem  = rem_shift[REM_W-1:0];
            stage_next.root = {stage_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.enable) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

[rtl/atp_cordic_cell.sv]
// ----------------------------------------------------------------------------
// atp_cordic_cell
// One vectoring CORDIC micro-rotation with a fixed shift and angle entry.
// ----------------------------------------------------------------------------
module atp_cordic_cell import atp_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic          aclk,
    input  pipe_ctrl_t    ctrl,
    input  cordic_stage_t stage_in,
    output cordic_stage_t stage_out
);

    logic signed [XY_W-1:0] x_in, y_in, dx, dy;
    logic signed [Z_W-1:0]  z_in;
    cordic_stage_t          stage_next, stage_reg;

    always_comb begin
        x_in = stage_in.x;
        y_in = stage_in.y;
        z_in = stage_in.z;
        dx   = y_in >>> STEP;
        dy   = x_in >>> STEP;
        stage_next.zero_vec = stage_in.zero_vec;
        if (!y_in[XY_W-1]) begin
            stage_next.x = x_in + dx;
            stage_next.y = y_in - dy;
            stage_next.z = z_in + ATAN_TABLE[STEP];
        end else begin
            stage_next.x = x_in - dx;
            stage_next.y = y_in + dy;
            stage_next.z = z_in - ATAN_TABLE[STEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.enable) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

[rtl/accel_tilt_pitch_angle.sv]
// ----------------------------------------------------------------------------
// accel_tilt_pitch_angle - accelerometer pitch angle and gyro pitch rate
// From accept to m_valid a transaction passes the radicand stage, 24 square root
// cells, the CORDIC cells and the output register; the squares load on the
// accepting edge itself.
// Throughput one transaction per cycle while the output is not stalled; synchronous reset clears valid bits.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_angle import atp_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF   // 8 .. 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [IN_W-1:0]    s_accel_x,
    input  logic signed [IN_W-1:0]    s_accel_y,
    input  logic signed [IN_W-1:0]    s_accel_z,
    input  logic signed [IN_W-1:0]    s_gyro_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ANGLE_W-1:0] m_pitch_angle,
    output logic signed [RATE_W-1:0]  m_pitch_rate
);

    // Stage map: [0] squares, [1] radicand, [2..25] sqrt cells, then CORDIC.
    localparam int PIPE_DEPTH = 2 + SQRT_STEPS + CORDIC_STEPS;
    localparam int RATE_LAT   = 3;
    localparam int RATE_DLY   = PIPE_DEPTH - RATE_LAT;

    localparam logic signed [Z_W:0] P_HI   = (Z_W+1)'(PITCH_LIMIT);
    localparam logic signed [Z_W:0] P_LO   = -P_HI;
    localparam logic signed [Z_W:0] P_BIAS = (Z_W+1)'(128);

    pipe_ctrl_t ctrl;

    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;
    logic                  m_valid_reg, m_valid_next;

    // ------------------------------------------------------------------
    // Flow control. Every stage moves together. The chain only holds when
    // the last stage carries a result and the output register is occupied
    // with m_ready low; a bubble at the end lets new transactions in regardless.
    // ------------------------------------------------------------------
    assign ctrl.enable = !vld_reg[PIPE_DEPTH-1] || !m_valid_reg || m_ready;
    assign s_ready     = ctrl.enable;

    always_comb begin
        vld_next = vld_reg;
        if (ctrl.enable) begin
            vld_next = {vld_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.enable && vld_reg[PIPE_DEPTH-1]) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: squares of the horizontal axes, zero-vector flag.
    // ------------------------------------------------------------------
    logic signed [HSQ_W-1:0] ax_ext, az_ext;
    logic [HSQ_W-1:0]        sq_x_reg, sq_z_reg;
    logic signed [IN_W-1:0]  ay_a_reg;
    logic                    zero_a_reg;

    assign ax_ext = HSQ_W'(s_accel_x);
    assign az_ext = HSQ_W'(s_accel_z);

    always_ff @(posedge aclk) begin
        if (ctrl.enable) begin
            sq_x_reg   <= HSQ_W'(ax_ext * ax_ext);
            sq_z_reg   <= HSQ_W'(az_ext * az_ext);
            ay_a_reg   <= s_accel_y;
            zero_a_reg <= (s_accel_x == '0) && (s_accel_y == '0) && (s_accel_z == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: radicand (ax^2 + az^2) * 2^16 into the root chain.
    // ------------------------------------------------------------------
    sqrt_stage_t sqrt_b_next, sqrt_b_reg;

    always_comb begin
        sqrt_b_next.rad      = {HSQ_W'(sq_x_reg + sq_z_reg), (RAD_W-HSQ_W)'(0)};
        sqrt_b_next.rem      = '0;
        sqrt_b_next.root     = '0;
        sqrt_b_next.ay       = ay_a_reg;
        sqrt_b_next.zero_vec = zero_a_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.enable) begin
            sqrt_b_reg <= sqrt_b_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root chain: one floored root bit per cell, MSB first.
    // ------------------------------------------------------------------
    sqrt_stage_t sstage [SQRT_STEPS+1];

    assign sstage[0] = sqrt_b_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        atp_sqrt_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .stage_in  (sstage[k]),
            .stage_out (sstage[k+1])
        );
    end

    // ------------------------------------------------------------------
    // CORDIC chain. x is the horizontal magnitude, y is ay, both with
    // 8 fraction bits; z gathers the angle in 2^-15 degree.
    // ------------------------------------------------------------------
    cordic_stage_t cstage [CORDIC_STEPS+1];

    always_comb begin
        cstage[0].x        = {{(XY_W-ROOT_W){1'b0}}, sstage[SQRT_STEPS].root};
        cstage[0].y        = {{(XY_W-IN_W-8){sstage[SQRT_STEPS].ay[IN_W-1]}},
                              sstage[SQRT_STEPS].ay, 8'b0};
        cstage[0].z        = '0;
        cstage[0].zero_vec = sstage[SQRT_STEPS].zero_vec;
    end

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
        atp_cordic_cell #(
            .STEP (j)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .stage_in  (cstage[j]),
            .stage_out (cstage[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Rate path: three stages of scaling, then a delay line to line up
    // with the angle at the end of the CORDIC chain.
    // ------------------------------------------------------------------
    logic signed [RATE_W-1:0] rate_c;
    logic signed [RATE_W-1:0] rate_dly_reg [RATE_DLY];

    atp_rate u_rate (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .gyro_y (s_gyro_y),
        .rate   (rate_c)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.enable) begin
            rate_dly_reg[0] <= rate_c;
            for (int k = 1; k < RATE_DLY; k++) begin
                rate_dly_reg[k] <= rate_dly_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: negate and round the angle to 1/128 degree,
    // saturate to +-90 degrees, force zero for an all-zero vector.
    // ------------------------------------------------------------------
    logic signed [Z_W-1:0]     z_last;
    logic signed [Z_W:0]       p_diff, p_full;
    logic signed [ANGLE_W-1:0] pitch_next, pitch_reg;
    logic signed [RATE_W-1:0]  rate_reg;

    always_comb begin
        z_last = cstage[CORDIC_STEPS].z;
        p_diff = P_BIAS - {z_last[Z_W-1], z_last};
        p_full = p_diff >>> 8;
        if (cstage[CORDIC_STEPS].zero_vec) begin
            pitch_next = '0;
        end else if (p_full > P_HI) begin
            pitch_next = ANGLE_W'(P_HI);
        end else if (p_full < P_LO) begin
            pitch_next = ANGLE_W'(P_LO);
        end else begin
            pitch_next = ANGLE_W'(p_full);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.enable && vld_reg[PIPE_DEPTH-1]) begin
            pitch_reg <= pitch_next;
            rate_reg  <= rate_dly_reg[RATE_DLY-1];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pitch_angle = pitch_reg;
    assign m_pitch_rate  = rate_reg;

endmodule

[rtl/atp_checker.sv]
// ----------------------------------------------------------------------------
// atp_checker
// Port-level checks on the tilt pitch block, bound to the top level.
// ----------------------------------------------------------------------------
`include "accel_tilt_pitch_angle_assert.svh"

module atp_checker import atp_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic signed [IN_W-1:0]    s_accel_x,
    input logic signed [IN_W-1:0]    s_accel_y,
    input logic signed [IN_W-1:0]    s_accel_z,
    input logic signed [IN_W-1:0]    s_gyro_y,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [ANGLE_W-1:0] m_pitch_angle,
    input logic signed [RATE_W-1:0]  m_pitch_rate
);

    localparam logic signed [ANGLE_W-1:0] ANG_HI  = ANGLE_W'(PITCH_LIMIT);
    localparam logic signed [ANGLE_W-1:0] ANG_LO  = -ANG_HI;
    localparam logic signed [RATE_W-1:0]  RATE_HI = RATE_W'(31968);
    localparam logic signed [RATE_W-1:0]  RATE_LO = RATE_W'(-31969);

    // a waiting input transaction holds its payload
    `ATP_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_accel_x) && $stable(s_accel_y) && $stable(s_accel_z) && $stable(s_gyro_y), "input changed while waiting")

    // a stalled result transaction holds its payload
    `ATP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pitch_angle) && $stable(m_pitch_rate), "result changed while stalled")

    // reset empties the output register
    `ATP_ASSERT_NEXT_ALWAYS(a_reset_clear, aclk, !aresetn, !m_valid, "result valid after reset")

    // angle saturates at plus or minus 90 degrees
    `ATP_ASSERT_NOW(a_angle_range, aclk, aresetn, m_valid, (m_pitch_angle <= ANG_HI) && (m_pitch_angle >= ANG_LO), "pitch angle out of range")

    // rate stays inside the scaled gyro range
    `ATP_ASSERT_NOW(a_rate_range, aclk, aresetn, m_valid, (m_pitch_rate <= RATE_HI) && (m_pitch_rate >= RATE_LO), "pitch rate out of range")

endmodule

bind accel_tilt_pitch_angle atp_checker u_atp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_accel_x     (s_accel_x),
    .s_accel_y     (s_accel_y),
    .s_accel_z     (s_accel_z),
    .s_gyro_y      (s_gyro_y),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pitch_angle (m_pitch_angle),
    .m_pitch_rate  (m_pitch_rate)
);
